### src/bpru_pkg.sv
// shared types, constants and helper functions of the bmp pixel row unpacker
package bpru_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int WIDTH_W     = 13;
   localparam int COL_W       = 12;
   localparam int ROW_BYTES_W = 15;
   localparam int PAL_DEPTH   = 256;
   localparam int PAL_AW      = 8;
   localparam int COLOR_W     = 24;
   localparam int CSR_AW      = 2;

   // register indexes of the configuration port
   localparam logic [CSR_AW-1:0] CSR_DEPTH = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WIDTH = 2'd1;

   typedef enum logic [2:0] {
      DEPTH_1  = 3'd0,
      DEPTH_4  = 3'd1,
      DEPTH_8  = 3'd2,
      DEPTH_24 = 3'd3,
      DEPTH_32 = 3'd4
   } depth_type;

   typedef enum logic [0:0] {
      MODE_PALETTE = 1'b0,
      MODE_PIXEL   = 1'b1
   } mode_type;

   typedef struct packed {
      logic                en;
      logic [PAL_AW-1:0]   addr;
      logic [COLOR_W-1:0]  data;
   } pal_wr_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
   } pal_rd_type;

   // undefined codes fall back to 8 bits per pixel
   function automatic depth_type norm_depth(logic [2:0] code);
      depth_type d;
      case (code)
         3'd0:    d = DEPTH_1;
         3'd1:    d = DEPTH_4;
         3'd3:    d = DEPTH_24;
         3'd4:    d = DEPTH_32;
         default: d = DEPTH_8;
      endcase
      return d;
   endfunction

   // zero width acts as one, oversize saturates
   function automatic logic [WIDTH_W-1:0] eff_width(logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      if (w == '0) begin
         r = WIDTH_W'(1);
      end else if (w > WIDTH_W'(MAX_WIDTH)) begin
         r = WIDTH_W'(MAX_WIDTH);
      end else begin
         r = w;
      end
      return r;
   endfunction

   // bytes per row, rounded up to a four-byte boundary
   function automatic logic [ROW_BYTES_W-1:0] row_bytes_f(logic [WIDTH_W-1:0] w,
                                                          depth_type d);
      logic [17:0] bits;
      logic [17:0] sum;
      case (d)
         DEPTH_1:  bits = {5'b0, w};
         DEPTH_4:  bits = {3'b0, w, 2'b0};
         DEPTH_24: bits = {2'b0, w, 3'b0} + {1'b0, w, 4'b0};
         DEPTH_32: bits = {w, 5'b0};
         default:  bits = {2'b0, w, 3'b0};
      endcase
      sum = bits + 18'd31;
      return {sum[17:5], 2'b00};
   endfunction

endpackage

### src/bpru_palette.sv
// 256-entry palette memory with one write port and a registered read port
module bpru_palette
   import bpru_pkg::*;
(
   input  logic               clock,
   input  pal_wr_type         wr,
   input  pal_rd_type         rd,
   output logic [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] mem_ff [PAL_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      // read data holds while the consumer stalls
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bmp_pixel_row_unpacker.sv
// top level of the bmp pixel row unpacker: byte unpacking, row tracking, output register
//
// req channel: one transaction per pixel-array byte or palette write. tuser[0] selects
//   palette write (0) or pixel byte (1); tdata carries palette index, palette color and
//   the data byte.
// rsp channel: one transaction per pixel; tdata holds red, green, blue and the column,
//   tuser[0] flags the last pixel of a row, tlast the final pixel of its input byte.
// csr port: write enable, register index, data; index 0 is the depth code, index 1 the
//   image width. a write to either register restarts the row.
// path: a byte waits in the input register, and each of its pixels in the output register,
//   which drives rsp.
// throughput: one pixel per cycle through the single palette read port while rsp does not
//   stall, so a byte yields up to 8 pixels at 1 bpp, up to 2 at 4 bpp and 1 at 8 bpp;
//   palette writes, padding bytes and the bytes of a 24/32 bpp pixel other than red
//   retire without a pixel and never wait for rsp.
// stall: the input register still takes a new byte while a pixel waits in the output
//   register; once the input register also holds a byte that cannot retire, req_tready drops.
// reset: clears the row position, the held color bytes and the valid flags, and loads
//   8 bpp with a width of one pixel; palette contents are undefined until written.
module bmp_pixel_row_unpacker
   import bpru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // palette_index, palette_color, data_byte
   input  logic [0:0]        req_tuser,   // mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // red, green, blue, pixel_column, zero fill
   output logic              rsp_tlast,   // last
   output logic [0:0]        rsp_tuser,   // row_end
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [12:0]       csr_wdata
);

   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

   // configuration
   depth_type                depth_ff, depth_in;
   logic [WIDTH_W-1:0]       width_ff, width_in;

   // input register
   logic                     a_valid_ff, a_valid_in;
   mode_type                 a_mode_ff, a_mode_in;
   logic [39:0]              a_data_ff, a_data_in;
   logic [2:0]               sub_ff, sub_in;      // pixel slot inside the byte

   // row position
   logic [ROW_BYTES_W-1:0]   rbc_ff, rbc_in;
   logic [WIDTH_W-1:0]       col_ff, col_in;      // can reach the width itself
   phase_type                phase_ff, phase_in;
   logic [7:0]               held_blue_ff, held_blue_in;
   logic [7:0]               held_green_ff, held_green_in;

   // output register
   logic                     b_valid_ff, b_valid_in;
   logic                     b_pal_ff, b_pal_in;  // color comes from the palette
   logic [COLOR_W-1:0]       b_rgb_ff, b_rgb_in;
   logic [COL_W-1:0]         b_col_ff, b_col_in;
   logic                     b_row_end_ff, b_row_end_in;
   logic                     b_last_ff, b_last_in;

   pal_wr_type               pal_wr;
   pal_rd_type               pal_rd;
   logic [COLOR_W-1:0]       pal_data;

   logic [ROW_BYTES_W-1:0]   row_bytes;
   logic [ROW_BYTES_W-1:0]   rbc_next;
   logic [PAL_AW-1:0]        ci;
   logic                     last_slot;
   logic                     row_end;
   logic                     col_open;
   logic                     out_ready;
   logic                     retire;
   logic                     accept;
   logic [7:0]               a_byte;
   logic [COLOR_W-1:0]       pixel_color;

   assign a_byte    = a_data_ff[39:32];
   assign row_bytes = row_bytes_f(width_ff, depth_ff);
   assign rbc_next  = rbc_ff + ROW_BYTES_W'(1);
   assign col_open  = col_ff < width_ff;
   assign row_end   = (col_ff + WIDTH_W'(1)) == width_ff;
   assign out_ready = !b_valid_ff || rsp_tready;

   // palette index of the current slot, msb first
   always_comb begin
      case (depth_ff)
         DEPTH_1: begin
            ci        = {7'b0, a_byte[3'd7 - sub_ff]};
            last_slot = sub_ff == 3'd7;
         end
         DEPTH_4: begin
            ci        = sub_ff[0] ? {4'b0, a_byte[3:0]} : {4'b0, a_byte[7:4]};
            last_slot = sub_ff[0];
         end
         default: begin
            ci        = a_byte;
            last_slot = 1'b1;
         end
      endcase
   end

   always_comb begin
      depth_in      = depth_ff;
      width_in      = width_ff;
      a_valid_in    = a_valid_ff;
      a_mode_in     = a_mode_ff;
      a_data_in     = a_data_ff;
      sub_in        = sub_ff;
      rbc_in        = rbc_ff;
      col_in        = col_ff;
      phase_in      = phase_ff;
      held_blue_in  = held_blue_ff;
      held_green_in = held_green_ff;
      b_valid_in    = b_valid_ff;
      b_pal_in      = b_pal_ff;
      b_rgb_in      = b_rgb_ff;
      b_col_in      = b_col_ff;
      b_row_end_in  = b_row_end_ff;
      b_last_in     = b_last_ff;
      retire        = 1'b0;
      pal_wr.en     = 1'b0;
      pal_wr.addr   = a_data_ff[7:0];
      pal_wr.data   = a_data_ff[31:8];
      pal_rd.en     = 1'b0;
      pal_rd.addr   = ci;

      // a taken pixel frees the output register
      if (rsp_tready) begin
         b_valid_in = 1'b0;
      end

      if (a_valid_ff) begin
         if (a_mode_ff == MODE_PALETTE) begin
            pal_wr.en = 1'b1;
            retire    = 1'b1;
         end else if (!col_open) begin
            // padding byte
            retire = 1'b1;
         end else if (depth_ff inside {DEPTH_1, DEPTH_4, DEPTH_8}) begin
            if (out_ready) begin
               pal_rd.en    = 1'b1;
               b_valid_in   = 1'b1;
               b_pal_in     = 1'b1;
               b_col_in     = col_ff[COL_W-1:0];
               b_row_end_in = row_end;
               b_last_in    = last_slot || row_end;
               col_in       = col_ff + WIDTH_W'(1);
               if (last_slot || row_end) begin
                  retire = 1'b1;
               end else begin
                  sub_in = sub_ff + 3'd1;
               end
            end
         end else begin
            case (phase_ff)
               PH_BLUE: begin
                  held_blue_in = a_byte;
                  phase_in     = PH_GREEN;
                  retire       = 1'b1;
               end
               PH_GREEN: begin
                  held_green_in = a_byte;
                  phase_in      = PH_RED;
                  retire        = 1'b1;
               end
               PH_RED: begin
                  if (out_ready) begin
                     b_valid_in   = 1'b1;
                     b_pal_in     = 1'b0;
                     b_rgb_in     = {a_byte, held_green_ff, held_blue_ff};
                     b_col_in     = col_ff[COL_W-1:0];
                     b_row_end_in = row_end;
                     b_last_in    = 1'b1;
                     col_in       = col_ff + WIDTH_W'(1);
                     phase_in     = (depth_ff == DEPTH_32) ? PH_SKIP : PH_BLUE;
                     retire       = 1'b1;
                  end
               end
               default: begin
                  // fourth byte at 32 bpp
                  phase_in = PH_BLUE;
                  retire   = 1'b1;
               end
            endcase
         end

         // byte done: advance the row and restart at its end
         if (retire && a_mode_ff == MODE_PIXEL) begin
            sub_in = 3'd0;
            rbc_in = rbc_next;
            if (rbc_next >= row_bytes) begin
               rbc_in        = '0;
               col_in        = '0;
               phase_in      = PH_BLUE;
               held_blue_in  = '0;
               held_green_in = '0;
            end
         end
      end

      accept = req_tvalid && (!a_valid_ff || retire);
      if (accept) begin
         a_valid_in = 1'b1;
         a_mode_in  = mode_type'(req_tuser[0]);
         a_data_in  = req_tdata;
      end else if (retire) begin
         a_valid_in = 1'b0;
      end

      // the user must write the configuration only while idle; the block does not enforce it
      if (csr_we && (csr_addr == CSR_DEPTH || csr_addr == CSR_WIDTH)) begin
         if (csr_addr == CSR_DEPTH) begin
            depth_in = norm_depth(csr_wdata[2:0]);
         end else begin
            width_in = eff_width(csr_wdata);
         end
         rbc_in        = '0;
         col_in        = '0;
         phase_in      = PH_BLUE;
         held_blue_in  = '0;
         held_green_in = '0;
         sub_in        = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= DEPTH_8;
         width_ff      <= WIDTH_W'(1);
         a_valid_ff    <= 1'b0;
         sub_ff        <= 3'd0;
         rbc_ff        <= '0;
         col_ff        <= '0;
         phase_ff      <= PH_BLUE;
         held_blue_ff  <= '0;
         held_green_ff <= '0;
         b_valid_ff    <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         width_ff      <= width_in;
         a_valid_ff    <= a_valid_in;
         sub_ff        <= sub_in;
         rbc_ff        <= rbc_in;
         col_ff        <= col_in;
         phase_ff      <= phase_in;
         held_blue_ff  <= held_blue_in;
         held_green_ff <= held_green_in;
         b_valid_ff    <= b_valid_in;
      end
      a_mode_ff    <= a_mode_in;
      a_data_ff    <= a_data_in;
      b_pal_ff     <= b_pal_in;
      b_rgb_ff     <= b_rgb_in;
      b_col_ff     <= b_col_in;
      b_row_end_ff <= b_row_end_in;
      b_last_ff    <= b_last_in;
   end

   bpru_palette u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_data (pal_data)
   );

   // color is {red, green, blue} from the top bit down
   assign pixel_color = b_pal_ff ? pal_data : b_rgb_ff;

   assign req_tready = !a_valid_ff || retire;
   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {4'b0, b_col_ff, pixel_color[7:0], pixel_color[15:8],
                        pixel_color[23:16]};
   assign rsp_tlast  = b_last_ff;
   assign rsp_tuser  = b_row_end_ff;

endmodule

### src/bpru_checker.sv
// port-level checker of the bmp pixel row unpacker and its bind
module bpru_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // no pixel right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("pixel valid after reset");

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled pixel changed");

   // a row always ends on the final pixel of its byte
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("row end not on final pixel of byte");

   // pixels of one byte follow without a gap and in column order
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && rsp_tdata[35:24] == $past(rsp_tdata[35:24]) + 12'd1)
      else $error("pixel run broken");

endmodule

bind bmp_pixel_row_unpacker bpru_checker u_bpru_checker (.*);
